/* design/qts_pkg.sv */
// Shared types and constants of the quoted token splitter.
package qts_pkg;

  localparam int unsigned MaxResults = 3;

  localparam logic [7:0] CH_SINGLE       = 8'h27;
  localparam logic [7:0] CH_DOUBLE       = 8'h22;
  localparam logic [7:0] DEPTH_MAX       = 8'hFF;
  localparam logic [7:0] SEPARATOR_RESET = 8'd32;

  typedef enum logic [1:0] {
    KIND_BYTE       = 2'd0,
    KIND_TOKEN_END  = 2'd1,
    KIND_STREAM_END = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    QK_NONE   = 2'd0,
    QK_SINGLE = 2'd1,
    QK_DOUBLE = 2'd2
  } qkind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic       run_last;
  } out_t;

  typedef struct packed {
    qkind_e     quote_kind;
    logic [7:0] quote_depth;
    logic       trim_mode;
    logic       token_nonempty;
  } state_t;

  // All results caused by one input byte, first result in entry 0.
  typedef struct packed {
    out_t [MaxResults-1:0] res;
    logic [1:0]            count;
  } group_t;

endpackage

/* design/quoted_token_splitter_core.sv */
// Quoted token splitter top level: state, result buffering and handshakes.
//
// The block takes one byte per cycle when not stalled and splits the stream
// into tokens at the separator register, honoring nested single and double
// quotes. Every input transaction is processed in the cycle it is accepted;
// its results (zero to three) go into a result register that presents one
// result per cycle unless the receiver stalls; a second group slot lets the
// next byte be taken while results still wait. A one-result byte sustains one
// byte per cycle; a byte with more results holds the output until all are
// taken, so the input stalls once both group slots hold results. The output
// register sets the throughput. The separator resets to a space and may be
// rewritten at any time the block is idle.
module quoted_token_splitter_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  qts_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output qts_pkg::out_t  out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [7:0]     cfg_data_i
);

  qts_pkg::state_t state_q, state_d;
  logic [7:0]      sep_q;
  qts_pkg::group_t new_grp;

  qts_pkg::out_t [qts_pkg::MaxResults-1:0] g_res_q, g_res_d;
  logic [1:0]      g_cnt_q, g_cnt_d;
  qts_pkg::group_t p_grp_q, p_grp_d;
  logic            p_valid_q, p_valid_d;

  logic acc;
  logic pop;
  logic g_free;
  logic new_has;

  qts_step u_step (
    .state_i    (state_q),
    .separator_i(sep_q),
    .item_i     (in_data_i),
    .state_o    (state_d),
    .group_o    (new_grp)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = p_valid_q;
  assign acc         = in_valid_i && !in_stall_o;
  assign out_valid_o = (g_cnt_q != 2'd0);
  assign out_data_o  = g_res_q[0];
  assign pop         = out_valid_o && !out_stall_i;
  assign g_free      = (g_cnt_q == 2'd0) || (g_cnt_q == 2'd1 && pop);
  assign new_has     = acc && (new_grp.count != 2'd0);

  always_comb begin
    g_res_d   = g_res_q;
    g_cnt_d   = g_cnt_q;
    p_grp_d   = p_grp_q;
    p_valid_d = p_valid_q;
    if (g_free) begin
      if (p_valid_q) begin
        g_res_d   = p_grp_q.res;
        g_cnt_d   = p_grp_q.count;
        p_valid_d = 1'b0;
      end else if (new_has) begin
        g_res_d = new_grp.res;
        g_cnt_d = new_grp.count;
      end else begin
        g_cnt_d = 2'd0;
      end
    end else begin
      if (pop) begin
        for (int i = 0; i < qts_pkg::MaxResults - 1; i++) begin
          g_res_d[i] = g_res_q[i+1];
        end
        g_cnt_d = g_cnt_q - 2'd1;
      end
      if (new_has) begin
        p_grp_d   = new_grp;
        p_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '{quote_kind: qts_pkg::QK_NONE, quote_depth: 8'd0,
                     trim_mode: 1'b0, token_nonempty: 1'b0};
      sep_q     <= qts_pkg::SEPARATOR_RESET;
      g_cnt_q   <= 2'd0;
      p_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        state_q <= state_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sep_q <= cfg_data_i;
      end
      g_cnt_q   <= g_cnt_d;
      p_valid_q <= p_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    g_res_q <= g_res_d;
    p_grp_q <= p_grp_d;
  end

  // A pending group only waits behind a group that is still draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q |-> g_cnt_q != 2'd0)
    else $error("pending group held while the result register is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == qts_pkg::KIND_STREAM_END |-> out_data_o.run_last)
    else $error("end of stream is not the last result of its transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != qts_pkg::KIND_BYTE |-> out_data_o.out_byte == 8'd0)
    else $error("marker result carries a nonzero byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_data_i.in_last |=>
      state_q.quote_depth == 8'd0 && !state_q.token_nonempty && !state_q.trim_mode)
    else $error("state not cleared after the final byte of a stream");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q |-> p_grp_q.count != 2'd0)
    else $error("empty group queued");

endmodule

/* design/qts_step.sv */
// Combinational next-state and result logic for one input byte.
module qts_step (
  input  qts_pkg::state_t state_i,
  input  logic [7:0]      separator_i,
  input  qts_pkg::in_t    item_i,
  output qts_pkg::state_t state_o,
  output qts_pkg::group_t group_o
);

  qts_pkg::qkind_e qk;
  logic            emit_first;
  qts_pkg::out_t   first_res;
  logic            emit_flush;
  logic            emit_end;
  qts_pkg::state_t st_mid;

  always_comb begin
    if (item_i.in_byte == qts_pkg::CH_SINGLE) begin
      qk = qts_pkg::QK_SINGLE;
    end else if (item_i.in_byte == qts_pkg::CH_DOUBLE) begin
      qk = qts_pkg::QK_DOUBLE;
    end else begin
      qk = qts_pkg::QK_NONE;
    end
  end

  // Byte handling: quote tracking, separator and token bytes.
  always_comb begin
    st_mid     = state_i;
    emit_first = 1'b0;
    first_res  = '{kind: qts_pkg::KIND_BYTE, out_byte: item_i.in_byte, run_last: 1'b0};
    if (item_i.in_byte != 8'd0) begin
      if (state_i.quote_depth != 8'd0) begin
        if (qk != qts_pkg::QK_NONE && state_i.quote_kind != qts_pkg::QK_NONE) begin
          if (state_i.quote_kind == qk) begin
            st_mid.quote_depth = state_i.quote_depth - 8'd1;
            if (state_i.quote_depth != 8'd1) begin
              st_mid.quote_kind = (state_i.quote_kind == qts_pkg::QK_SINGLE) ?
                                  qts_pkg::QK_DOUBLE : qts_pkg::QK_SINGLE;
            end else begin
              st_mid.quote_kind = qts_pkg::QK_NONE;
            end
          end else begin
            if (state_i.quote_depth != qts_pkg::DEPTH_MAX) begin
              st_mid.quote_depth = state_i.quote_depth + 8'd1;
            end
            st_mid.quote_kind = qk;
          end
        end
        emit_first            = 1'b1;
        st_mid.token_nonempty = 1'b1;
      end else begin
        if (qk != qts_pkg::QK_NONE) begin
          st_mid.quote_kind  = qk;
          st_mid.quote_depth = 8'd1;
        end
        if (item_i.in_byte == separator_i) begin
          if (!state_i.trim_mode && state_i.token_nonempty) begin
            emit_first            = 1'b1;
            first_res.kind        = qts_pkg::KIND_TOKEN_END;
            first_res.out_byte    = 8'd0;
            st_mid.token_nonempty = 1'b0;
          end
          st_mid.trim_mode = 1'b1;
        end else begin
          st_mid.trim_mode      = 1'b0;
          emit_first            = 1'b1;
          st_mid.token_nonempty = 1'b1;
        end
      end
    end
  end

  assign emit_flush = item_i.in_last && st_mid.token_nonempty;
  assign emit_end   = item_i.in_last;

  always_comb begin
    if (item_i.in_last) begin
      state_o = '{quote_kind: qts_pkg::QK_NONE, quote_depth: 8'd0,
                  trim_mode: 1'b0, token_nonempty: 1'b0};
    end else begin
      state_o = st_mid;
    end
  end

  // Pack the results in order and flag the final one.
  always_comb begin
    logic [1:0] idx;
    idx     = 2'd0;
    group_o = '0;
    if (emit_first) begin
      group_o.res[idx] = first_res;
      idx              = idx + 2'd1;
    end
    if (emit_flush) begin
      group_o.res[idx] = '{kind: qts_pkg::KIND_TOKEN_END, out_byte: 8'd0, run_last: 1'b0};
      idx              = idx + 2'd1;
    end
    if (emit_end) begin
      group_o.res[idx] = '{kind: qts_pkg::KIND_STREAM_END, out_byte: 8'd0, run_last: 1'b0};
      idx              = idx + 2'd1;
    end
    group_o.count = idx;
    if (idx != 2'd0) begin
      group_o.res[idx - 2'd1].run_last = 1'b1;
    end
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the quoted token splitter core.
module tb;

  localparam int unsigned HOLD_CYCLES = 40;
  localparam int unsigned IDLE_TAIL = 8;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned PHASE_BYTES = 8;
  localparam int unsigned NEST_QUOTES = 258;
  localparam int unsigned MAX_REPORTS = 10;

  // Tracks the splitter state and holds the results still owed by the block.
  class token_splitter_scoreboard;
    logic [7:0] separator;
    qts_pkg::qkind_e quote_kind;
    logic [7:0] quote_depth;
    bit trim_mode;
    bit token_nonempty;
    qts_pkg::out_t expected_tokens[$];
    int unsigned errors;
    int unsigned bytes_seen;
    int unsigned results_checked;
    int unsigned deepest;

    function new();
      separator = qts_pkg::SEPARATOR_RESET;
      errors = 0;
      bytes_seen = 0;
      results_checked = 0;
      deepest = 0;
      clear_quotes();
    endfunction

    function void clear_quotes();
      quote_kind = qts_pkg::QK_NONE;
      quote_depth = 8'd0;
      trim_mode = 1'b0;
      token_nonempty = 1'b0;
    endfunction

    function void set_separator(logic [7:0] value);
      separator = value;
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] error: %s", $realtime, msg);
    endfunction

    // A quote byte seen while a quote is open either closes one level or
    // nests one deeper with the other quote kind.
    function void nest_quote(qts_pkg::qkind_e qk);
      if (quote_kind == qts_pkg::QK_NONE) return;
      if (quote_kind == qk) begin
        if (quote_depth != 8'd0) quote_depth = quote_depth - 8'd1;
        if (quote_depth != 8'd0) begin
          quote_kind = (quote_kind == qts_pkg::QK_SINGLE) ?
                       qts_pkg::QK_DOUBLE : qts_pkg::QK_SINGLE;
        end else begin
          quote_kind = qts_pkg::QK_NONE;
        end
      end else begin
        if (quote_depth < qts_pkg::DEPTH_MAX) quote_depth = quote_depth + 8'd1;
        quote_kind = qk;
      end
    endfunction

    function void note_input_byte(qts_pkg::in_t item);
      qts_pkg::out_t step_results[$];
      qts_pkg::out_t res;
      qts_pkg::qkind_e qk;
      logic [7:0] b;
      b = item.in_byte;
      bytes_seen++;
      res.kind = qts_pkg::KIND_BYTE;
      res.out_byte = 8'd0;
      res.run_last = 1'b0;
      if (b != 8'd0) begin
        if (b == qts_pkg::CH_SINGLE) begin
          qk = qts_pkg::QK_SINGLE;
        end else if (b == qts_pkg::CH_DOUBLE) begin
          qk = qts_pkg::QK_DOUBLE;
        end else begin
          qk = qts_pkg::QK_NONE;
        end
        if (quote_depth != 8'd0) begin
          if (qk != qts_pkg::QK_NONE) nest_quote(qk);
          res.kind = qts_pkg::KIND_BYTE;
          res.out_byte = b;
          step_results.push_back(res);
          token_nonempty = 1'b1;
        end else begin
          if (qk != qts_pkg::QK_NONE) begin
            quote_kind = qk;
            quote_depth = 8'd1;
          end
          // A quote byte equal to the separator opens a quote and still splits.
          if (b == separator) begin
            if (!trim_mode && token_nonempty) begin
              res.kind = qts_pkg::KIND_TOKEN_END;
              res.out_byte = 8'd0;
              step_results.push_back(res);
              token_nonempty = 1'b0;
            end
            trim_mode = 1'b1;
          end else begin
            trim_mode = 1'b0;
            res.kind = qts_pkg::KIND_BYTE;
            res.out_byte = b;
            step_results.push_back(res);
            token_nonempty = 1'b1;
          end
        end
        if (quote_depth > deepest) deepest = quote_depth;
      end
      if (item.in_last) begin
        res.out_byte = 8'd0;
        if (token_nonempty) begin
          res.kind = qts_pkg::KIND_TOKEN_END;
          step_results.push_back(res);
        end
        res.kind = qts_pkg::KIND_STREAM_END;
        step_results.push_back(res);
        clear_quotes();
      end
      if (step_results.size() > 0) step_results[step_results.size()-1].run_last = 1'b1;
      foreach (step_results[i]) expected_tokens.push_back(step_results[i]);
    endfunction

    function void check_token_result(qts_pkg::out_t got);
      qts_pkg::out_t want;
      results_checked++;
      if (expected_tokens.size() == 0) begin
        flag_error($sformatf("unexpected result kind=%0d byte=%02h last=%0b",
                             got.kind, got.out_byte, got.run_last));
        return;
      end
      want = expected_tokens.pop_front();
      if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
          got.run_last !== want.run_last) begin
        flag_error($sformatf(
          "result %0d: expected kind=%0d byte=%02h last=%0b, got kind=%0d byte=%02h last=%0b",
          results_checked, want.kind, want.out_byte, want.run_last,
          got.kind, got.out_byte, got.run_last));
      end
    endfunction

    function int unsigned pending();
      return expected_tokens.size();
    endfunction

    function bit clean();
      return errors == 0 && expected_tokens.size() == 0;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  qts_pkg::in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  qts_pkg::out_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [7:0] cfg_data_i;

  token_splitter_scoreboard sb = new();

  bit steady;
  bit long_hold_req;
  logic [7:0] current_sep;
  int unsigned bytes_sent;
  int unsigned sep_writes;
  int unsigned cycle_count;
  qts_pkg::in_t stim_q[$];

  quoted_token_splitter_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("FAIL quoted_token_splitter_core");
      $finish;
    end
  end

  // Inputs are noted before outputs are checked so that a same-cycle result
  // would still find its expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_input_byte(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_token_result(out_data_o);
    end
  end

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic qts_pkg::in_t mk(logic [7:0] b, logic last);
    qts_pkg::in_t item;
    item.in_byte = b;
    item.in_last = last;
    return item;
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'h61 + 8'($urandom_range(0, 25));
    if (r < 45) return current_sep;
    if (r < 58) return qts_pkg::CH_SINGLE;
    if (r < 71) return qts_pkg::CH_DOUBLE;
    if (r < 76) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // Receiver: random stalls per result, plus one long hold on request.
  initial begin
    int stall_gap;
    out_stall_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        long_hold_req = 1'b0;
      end
      stall_gap = draw_gap();
      if (stall_gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o && !long_hold_req);
    end
  end

  task automatic offer(qts_pkg::in_t item);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  task automatic play_queue();
    while (stim_q.size() > 0) offer(stim_q.pop_front());
  endtask

  // Waits until every owed result has been taken, then lets the block settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (IDLE_TAIL) @(posedge clk_i);
  endtask

  task automatic write_separator(logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_separator(value);
    current_sep = value;
    sep_writes++;
  endtask

  task automatic send_random_string();
    int len;
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) offer(mk(pick_byte(), i == len - 1));
  endtask

  initial begin
    logic [7:0] sep_plan[8];
    int unsigned phase_start;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 8'd0;
    rst_ni = 1'b0;
    steady = 1'b0;
    long_hold_req = 1'b0;
    current_sep = qts_pkg::SEPARATOR_RESET;
    bytes_sent = 0;
    sep_writes = 0;
    cycle_count = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset separator: collapsing separators, ignored zeros, nested quotes,
    // flush on the last byte with and without an open token or quote.
    stim_q.push_back(mk(8'h61, 1'b0));
    stim_q.push_back(mk(8'h20, 1'b0));
    stim_q.push_back(mk(8'h20, 1'b0));
    stim_q.push_back(mk(8'h00, 1'b0));
    stim_q.push_back(mk(8'hFF, 1'b0));
    stim_q.push_back(mk(8'h01, 1'b0));
    stim_q.push_back(mk(qts_pkg::CH_SINGLE, 1'b0));
    stim_q.push_back(mk(8'h20, 1'b0));
    stim_q.push_back(mk(qts_pkg::CH_DOUBLE, 1'b0));
    stim_q.push_back(mk(qts_pkg::CH_DOUBLE, 1'b0));
    stim_q.push_back(mk(qts_pkg::CH_SINGLE, 1'b0));
    stim_q.push_back(mk(8'h20, 1'b0));
    stim_q.push_back(mk(8'h00, 1'b1));
    stim_q.push_back(mk(8'h62, 1'b1));
    stim_q.push_back(mk(qts_pkg::CH_DOUBLE, 1'b0));
    stim_q.push_back(mk(8'h71, 1'b1));
    stim_q.push_back(mk(8'h20, 1'b1));
    play_queue();

    // Separator equal to the single quote: it opens a quote and splits, and
    // a later separator while still trimming must not end the token again.
    wait_idle();
    write_separator(qts_pkg::CH_SINGLE);
    stim_q.push_back(mk(8'h78, 1'b0));
    stim_q.push_back(mk(qts_pkg::CH_SINGLE, 1'b0));
    stim_q.push_back(mk(8'h79, 1'b0));
    stim_q.push_back(mk(qts_pkg::CH_SINGLE, 1'b0));
    stim_q.push_back(mk(qts_pkg::CH_SINGLE, 1'b1));
    play_queue();

    // Alternating quotes deep enough to saturate the nesting depth.
    wait_idle();
    write_separator(qts_pkg::SEPARATOR_RESET);
    stim_q.push_back(mk(8'h6B, 1'b0));
    stim_q.push_back(mk(qts_pkg::CH_SINGLE, 1'b0));
    for (int i = 0; i < NEST_QUOTES; i++) begin
      stim_q.push_back(mk((i % 2 == 0) ? qts_pkg::CH_DOUBLE : qts_pkg::CH_SINGLE, 1'b0));
    end
    stim_q.push_back(mk(8'h20, 1'b0));
    stim_q.push_back(mk(qts_pkg::CH_SINGLE, 1'b0));
    stim_q.push_back(mk(qts_pkg::CH_DOUBLE, 1'b0));
    stim_q.push_back(mk(8'h65, 1'b1));
    play_queue();

    sep_plan[0] = qts_pkg::SEPARATOR_RESET;
    sep_plan[1] = 8'h00;
    sep_plan[2] = 8'hFF;
    sep_plan[3] = qts_pkg::CH_DOUBLE;
    sep_plan[4] = 8'($urandom_range(1, 255));
    sep_plan[5] = 8'($urandom_range(0, 255));
    sep_plan[6] = qts_pkg::CH_SINGLE;
    sep_plan[7] = qts_pkg::SEPARATOR_RESET;
    foreach (sep_plan[p]) begin
      wait_idle();
      write_separator(sep_plan[p]);
      steady = (p % 3 == 2);
      // The first phase streams without gaps into a long receiver hold so
      // the result slots fill and the input stalls.
      if (p == 0) begin
        steady = 1'b1;
        long_hold_req = 1'b1;
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_random_string();
    end

    steady = 1'b0;
    wait_idle();
    if (sb.pending() != 0) sb.flag_error($sformatf("%0d results never arrived", sb.pending()));
    $display("Run covered %0d input bytes and %0d results over %0d separator writes.",
             sb.bytes_seen, sb.results_checked, sep_writes);
    $display("Deepest quote nesting reached %0d; %0d errors.", sb.deepest, sb.errors);
    if (sb.clean()) begin
      $display("PASS quoted_token_splitter_core");
    end else begin
      $display("FAIL quoted_token_splitter_core");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/qts_pkg.sv
design/qts_step.sv
design/quoted_token_splitter_core.sv
verif/tb.sv
